/* rtl/odh_pkg.sv */
// Package for the first-occurrence hash set: constants, register codes and shared types.
package odh_pkg;

	localparam int unsigned SLOTS_DEF  = 4096;
	localparam int unsigned PROBES_DEF = 64;
	localparam int unsigned DOMAINS    = 22;

	localparam int unsigned KEY_W     = 32;
	localparam int unsigned DOMAIN_W  = 5;
	localparam int unsigned LEVEL_W   = 3;
	localparam int unsigned THR_W     = 3;
	localparam int unsigned THR_LOW_W = 48;
	localparam int unsigned THR_HI_W  = 18;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 48;

	localparam logic [KEY_W-1:0]     DOMAIN_MIX     = 32'h9E37_79B9;
	localparam logic [KEY_W-1:0]     HASH_MUL       = 32'h7FEB_352D;
	localparam logic [THR_LOW_W-1:0] THR_LOW_RESET  = 48'd80421421917330;
	localparam logic [THR_HI_W-1:0]  THR_HIGH_RESET = 18'd74898;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THR_LOW  = 2'd0,
		REG_THR_HIGH = 2'd1
	} cfg_reg_t;

	typedef enum logic [0:0] {
		OP_CHECK = 1'b0,
		OP_CLEAR = 1'b1
	} op_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic wr_valid;
	} tbl_ctl_t;

endpackage

/* rtl/odh_hash.sv */
// Two-stage key mixer: domain mix on load, then xor-shift and multiply hash.
module odh_hash import odh_pkg::*; #(
	parameter int unsigned SLOTS = SLOTS_DEF,
	localparam int unsigned IDX_W = $clog2(SLOTS)
) (
	input  logic                clk,
	input  logic                load,
	input  logic [DOMAIN_W-1:0] domain,
	input  logic [KEY_W-1:0]    event_key,
	output logic [KEY_W-1:0]    mixed,
	output logic [IDX_W-1:0]    slot_idx
);

	logic [KEY_W-1:0] mixed_s1;
	logic [KEY_W-1:0] prod_s2;
	logic [KEY_W-1:0] dom_mix;
	logic [KEY_W-1:0] shift1;
	logic [KEY_W-1:0] hash_full;

	assign dom_mix   = KEY_W'(KEY_W'(domain) * DOMAIN_MIX);
	assign shift1    = mixed_s1 ^ (mixed_s1 >> 16);
	assign hash_full = prod_s2 ^ (prod_s2 >> 15);
	assign mixed     = mixed_s1;
	assign slot_idx  = hash_full[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (load) begin
			mixed_s1 <= event_key ^ dom_mix;
		end
		prod_s2 <= KEY_W'(shift1 * HASH_MUL);
	end

endmodule

/* rtl/odh_table.sv */
// Slot table: one synchronous memory of valid mark and key per slot.
module odh_table import odh_pkg::*; #(
	parameter int unsigned SLOTS = SLOTS_DEF,
	localparam int unsigned IDX_W = $clog2(SLOTS)
) (
	input  logic             clk,
	input  tbl_ctl_t         ctl,
	input  logic [IDX_W-1:0] rd_addr,
	input  logic [IDX_W-1:0] wr_addr,
	input  logic [KEY_W-1:0] wr_key,
	output logic             rd_valid,
	output logic [KEY_W-1:0] rd_key
);

	logic [KEY_W:0] mem [SLOTS];
	logic [KEY_W:0] rd_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= {ctl.wr_valid, wr_key};
		end
		if (ctl.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_valid = rd_q[KEY_W];
	assign rd_key   = rd_q[KEY_W-1:0];

endmodule

/* rtl/once_dedup_hash_set_top.sv */
// Top level of the first-occurrence filter on a linearly probed hash set.
//
// Command channel: an item is taken when start is high and busy is low.
// op selects a check (insert the mixed key, report if new and level is within the domain threshold) or a clear.
// Each item gives exactly one result: done is high for one cycle with
// report, seen_before and not_stored; the receiver cannot stall it.
// A check loads the domain mix on accept, then does the hash multiply,
// then issues the first table read, then checks the probed slots one at
// a time through the read port of the slot memory, 1 to PROBES of them.
// A clear rewrites every valid mark, one slot per cycle; busy is low
// again in the cycle in which done is high. After reset the same pass runs
// with busy high and gives no result. Threshold registers take writes on
// the cfg channel at any time; cfg_ready is always high. Thresholds reset
// to level 2 in every domain.
module once_dedup_hash_set_top import odh_pkg::*; #(
	parameter int unsigned SLOTS  = SLOTS_DEF,
	parameter int unsigned PROBES = PROBES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 op,
	input  logic [DOMAIN_W-1:0]  domain,
	input  logic [LEVEL_W-1:0]   level,
	input  logic [KEY_W-1:0]     event_key,
	output logic                 done,
	output logic                 report,
	output logic                 seen_before,
	output logic                 not_stored,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	localparam int unsigned IDX_W = $clog2(SLOTS);
	localparam int unsigned PRB_W = (PROBES > 1) ? $clog2(PROBES) : 1;

	typedef enum logic [5:0] {
		ST_INIT  = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_HASH  = 6'b000100,
		ST_READ  = 6'b001000,
		ST_CHECK = 6'b010000,
		ST_CLEAR = 6'b100000
	} state_t;

	state_t                state_q;
	logic [IDX_W-1:0]      addr_q;
	logic [PRB_W-1:0]      probe_q;
	logic [DOMAIN_W-1:0]   domain_q;
	logic [LEVEL_W-1:0]    level_q;
	logic [THR_LOW_W-1:0]  thr_low_q;
	logic [THR_HI_W-1:0]   thr_high_q;
	logic                  done_q;
	logic                  report_q;
	logic                  seen_q;
	logic                  full_q;

	logic                  accept;
	logic [KEY_W-1:0]      mixed;
	logic [IDX_W-1:0]      slot_idx;
	logic                  rd_valid;
	logic [KEY_W-1:0]      rd_key;
	logic [IDX_W-1:0]      rd_addr;
	tbl_ctl_t              tbl_ctl;
	logic [THR_LOW_W+THR_HI_W-1:0] thr_all;
	logic [THR_W-1:0]      thr_sel;
	logic                  passes;
	logic                  key_match;
	logic                  last_probe;
	logic                  sweep_end;

	assign accept     = start && !busy;
	assign busy       = (state_q != ST_IDLE);
	assign cfg_ready  = 1'b1;
	assign done       = done_q;
	assign report     = report_q;
	assign seen_before = seen_q;
	assign not_stored = full_q;

	assign key_match  = (rd_key == mixed);
	assign last_probe = (probe_q == PRB_W'(PROBES - 1));
	assign sweep_end  = (addr_q == IDX_W'(SLOTS - 1));
	assign thr_all    = {thr_high_q, thr_low_q};

	always_comb begin
		thr_sel = '0;
		for (int i = 0; i < DOMAINS; i++) begin
			if (domain_q == DOMAIN_W'(i)) begin
				thr_sel = thr_all[THR_W*i +: THR_W];
			end
		end
	end

	assign passes = (domain_q < DOMAIN_W'(DOMAINS)) && ({1'b0, level_q} <= {1'b0, thr_sel});

	always_comb begin
		tbl_ctl  = '0;
		rd_addr  = addr_q + IDX_W'(1);
		unique case (state_q)
			ST_INIT, ST_CLEAR: begin
				tbl_ctl.wr_en = 1'b1;
			end
			ST_READ: begin
				tbl_ctl.rd_en = 1'b1;
				rd_addr       = slot_idx;
			end
			ST_CHECK: begin
				if (!rd_valid) begin
					tbl_ctl.wr_en    = 1'b1;
					tbl_ctl.wr_valid = 1'b1;
				end else if (!key_match && !last_probe) begin
					tbl_ctl.rd_en = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	odh_hash #(
		.SLOTS(SLOTS)
	) u_hash (
		.clk       (clk),
		.load      (accept),
		.domain    (domain),
		.event_key (event_key),
		.mixed     (mixed),
		.slot_idx  (slot_idx)
	);

	odh_table #(
		.SLOTS(SLOTS)
	) u_table (
		.clk      (clk),
		.ctl      (tbl_ctl),
		.rd_addr  (rd_addr),
		.wr_addr  (addr_q),
		.wr_key   (mixed),
		.rd_valid (rd_valid),
		.rd_key   (rd_key)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_low_q  <= THR_LOW_RESET;
			thr_high_q <= THR_HIGH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_THR_LOW:  thr_low_q  <= cfg_data[THR_LOW_W-1:0];
				REG_THR_HIGH: thr_high_q <= cfg_data[THR_HI_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			domain_q <= domain;
			level_q  <= level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_INIT;
			addr_q   <= '0;
			probe_q  <= '0;
			done_q   <= 1'b0;
			report_q <= 1'b0;
			seen_q   <= 1'b0;
			full_q   <= 1'b0;
		end else begin
			done_q   <= 1'b0;
			report_q <= 1'b0;
			seen_q   <= 1'b0;
			full_q   <= 1'b0;
			unique case (state_q)
				ST_INIT: begin
					addr_q <= addr_q + IDX_W'(1);
					if (sweep_end) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						addr_q <= '0;
						if (op_t'(op) == OP_CLEAR) begin
							state_q <= ST_CLEAR;
						end else begin
							state_q <= ST_HASH;
						end
					end
				end
				ST_HASH: begin
					state_q <= ST_READ;
				end
				ST_READ: begin
					addr_q  <= slot_idx;
					probe_q <= '0;
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (!rd_valid) begin
						done_q   <= 1'b1;
						report_q <= passes;
						state_q  <= ST_IDLE;
					end else if (key_match) begin
						done_q  <= 1'b1;
						seen_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (last_probe) begin
						done_q   <= 1'b1;
						report_q <= passes;
						full_q   <= 1'b1;
						state_q  <= ST_IDLE;
					end else begin
						addr_q  <= addr_q + IDX_W'(1);
						probe_q <= probe_q + PRB_W'(1);
					end
				end
				ST_CLEAR: begin
					addr_q <= addr_q + IDX_W'(1);
					if (sweep_end) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_INIT;
				end
			endcase
		end
	end

	a_seen_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done && seen_before |-> !report && !not_stored)
		else $error("seen_before with report or not_stored");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result given while still busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item left block idle");

	a_insert_check: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_ctl.wr_en && tbl_ctl.wr_valid |-> state_q == ST_CHECK && !rd_valid)
		else $error("slot marked valid outside an empty-slot probe");

endmodule
